### hw/rtl/lrf_pkg.sv
package lrf_pkg;

    localparam int COORD_WIDTH = 9;
    localparam int DIM_W       = 10;
    localparam int COLOR_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int BUS_VAL_W   = 16;
    localparam int STEP_W      = 4;
    localparam int PIX_W       = DIM_W + 1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [BYTE_W-1:0] CMD_CASET = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_PASET = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_RAMWR = 8'h2C;

    localparam logic [STEP_W-1:0] HEADER_LEN = 4'd12;

    typedef struct packed {
        logic                   opcode;
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [DIM_W-1:0]       width;
        logic [DIM_W-1:0]       height;
        logic [COLOR_W-1:0]     color;
    } t_req;

    typedef struct packed {
        logic              write_valid;
        logic              is_data;
        logic [BYTE_W-1:0] bus_byte;
        logic              last;
        logic              busy_res;
        logic              start_ignored;
    } t_res;

    typedef struct packed {
        logic                   is_start;
        logic                   nonempty;
        logic [BUS_VAL_W-1:0]   col_start;
        logic [BUS_VAL_W-1:0]   col_end;
        logic [COORD_WIDTH-1:0] top_row;
        logic [DIM_W-1:0]       fill_width;
        logic [DIM_W-1:0]       fill_height;
        logic [COLOR_W-1:0]     color;
    } t_cmd;

    typedef struct packed {
        logic [Q_LVL_W-1:0] level;
        logic               full;
        logic               empty;
    } t_q_status;

endpackage

### hw/rtl/lrf_req_if.sv
interface lrf_req_if import lrf_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lrf_res_if.sv
interface lrf_res_if import lrf_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lrf_front.sv
module lrf_front import lrf_pkg::*; (
    lrf_req_if.sink i_req,
    input  logic    i_cmd_ready,
    output logic    o_cmd_valid,
    output t_cmd    o_cmd
);

    assign o_cmd_valid = i_req.valid;
    assign i_req.ready = i_cmd_ready;

    always_comb begin
        o_cmd.is_start    = (i_req.data.opcode == OP_START);
        o_cmd.nonempty    = (i_req.data.width != '0) && (i_req.data.height != '0);
        o_cmd.col_start   = BUS_VAL_W'(i_req.data.x);
        o_cmd.col_end     = BUS_VAL_W'(i_req.data.x) + BUS_VAL_W'(i_req.data.width)
                            - BUS_VAL_W'(1);
        o_cmd.top_row     = i_req.data.y;
        o_cmd.fill_width  = i_req.data.width;
        o_cmd.fill_height = i_req.data.height;
        o_cmd.color       = i_req.data.color;
    end

endmodule

### hw/rtl/lrf_queue.sv
module lrf_queue import lrf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push_valid,
    input  t_cmd      i_push_cmd,
    output logic      o_push_ready,
    output logic      o_pop_valid,
    output t_cmd      o_pop_cmd,
    input  logic      i_pop_ready,
    output t_q_status o_status
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_LVL_W-1:0] r_level;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_level != Q_LVL_W'(Q_DEPTH));
    assign o_pop_valid  = (r_level != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    assign o_status.level = r_level;
    assign o_status.full  = !o_push_ready;
    assign o_status.empty = !o_pop_valid;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
            return '0;
        end
        return p + Q_PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_level <= r_level + Q_LVL_W'(1);
            end else if (pop && !push) begin
                r_level <= r_level - Q_LVL_W'(1);
            end
        end
    end

endmodule

### hw/rtl/lrf_back.sv
module lrf_back import lrf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_ready,
    lrf_res_if.source  o_res
);

    localparam logic [STEP_W-1:0] STEP_RAMWR_A = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CASET   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_XS_HI   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_XS_LO   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_XE_HI   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_XE_LO   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_PASET   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_YS_HI   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_YS_LO   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_YE_HI   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_YE_LO   = 4'd10;

    logic                   r_active, n_active;
    logic [STEP_W-1:0]      r_step, n_step;
    logic [DIM_W-1:0]       r_row, n_row;
    logic [PIX_W-1:0]       r_pix, n_pix;
    logic [BUS_VAL_W-1:0]   r_col_start, n_col_start;
    logic [BUS_VAL_W-1:0]   r_col_end, n_col_end;
    logic [COORD_WIDTH-1:0] r_top_row, n_top_row;
    logic [DIM_W-1:0]       r_fill_width, n_fill_width;
    logic [DIM_W-1:0]       r_fill_height, n_fill_height;
    logic [COLOR_W-1:0]     r_color, n_color;
    logic                   r_out_valid;
    t_res                   r_res, n_res;

    logic                   pop;
    logic [BUS_VAL_W-1:0]   row_val;
    logic [PIX_W-1:0]       pix_next;
    logic [DIM_W-1:0]       row_next;

    assign o_cmd_ready = !r_out_valid || o_res.ready;
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    assign row_val  = BUS_VAL_W'(r_top_row) + BUS_VAL_W'(r_row);
    assign pix_next = r_pix + PIX_W'(1);
    assign row_next = r_row + DIM_W'(1);

    always_comb begin
        n_active      = r_active;
        n_step        = r_step;
        n_row         = r_row;
        n_pix         = r_pix;
        n_col_start   = r_col_start;
        n_col_end     = r_col_end;
        n_top_row     = r_top_row;
        n_fill_width  = r_fill_width;
        n_fill_height = r_fill_height;
        n_color       = r_color;
        n_res         = '0;

        if (i_cmd.is_start) begin
            if (r_active) begin
                n_res.start_ignored = 1'b1;
            end else begin
                n_col_start   = i_cmd.col_start;
                n_col_end     = i_cmd.col_end;
                n_top_row     = i_cmd.top_row;
                n_fill_width  = i_cmd.fill_width;
                n_fill_height = i_cmd.fill_height;
                n_color       = i_cmd.color;
                n_step        = '0;
                n_row         = '0;
                n_pix         = '0;
                n_active      = i_cmd.nonempty;
            end
        end else if (r_active) begin
            n_res.write_valid = 1'b1;
            if (r_step < HEADER_LEN) begin
                n_step        = r_step + STEP_W'(1);
                n_res.is_data = 1'b1;
                case (r_step)
                    STEP_RAMWR_A: begin
                        n_res.is_data  = 1'b0;
                        n_res.bus_byte = CMD_RAMWR;
                    end
                    STEP_CASET: begin
                        n_res.is_data  = 1'b0;
                        n_res.bus_byte = CMD_CASET;
                    end
                    STEP_XS_HI: n_res.bus_byte = r_col_start[BUS_VAL_W-1 -: BYTE_W];
                    STEP_XS_LO: n_res.bus_byte = r_col_start[BYTE_W-1:0];
                    STEP_XE_HI: n_res.bus_byte = r_col_end[BUS_VAL_W-1 -: BYTE_W];
                    STEP_XE_LO: n_res.bus_byte = r_col_end[BYTE_W-1:0];
                    STEP_PASET: begin
                        n_res.is_data  = 1'b0;
                        n_res.bus_byte = CMD_PASET;
                    end
                    STEP_YS_HI: n_res.bus_byte = row_val[BUS_VAL_W-1 -: BYTE_W];
                    STEP_YS_LO: n_res.bus_byte = row_val[BYTE_W-1:0];
                    STEP_YE_HI: n_res.bus_byte = row_val[BUS_VAL_W-1 -: BYTE_W];
                    STEP_YE_LO: n_res.bus_byte = row_val[BYTE_W-1:0];
                    default: begin
                        n_res.is_data  = 1'b0;
                        n_res.bus_byte = CMD_RAMWR;
                    end
                endcase
            end else begin
                n_res.is_data  = 1'b1;
                n_res.bus_byte = r_pix[0] ? r_color[BYTE_W-1:0]
                                          : r_color[COLOR_W-1 -: BYTE_W];
                n_pix = pix_next;
                if (pix_next >= PIX_W'({r_fill_width, 1'b0})) begin
                    n_pix  = '0;
                    n_step = '0;
                    n_row  = row_next;
                    if (row_next >= r_fill_height) begin
                        n_res.last = 1'b1;
                        n_active   = 1'b0;
                        n_row      = '0;
                    end
                end
            end
        end

        n_res.busy_res = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_col_start   <= n_col_start;
            r_col_end     <= n_col_end;
            r_top_row     <= n_top_row;
            r_fill_width  <= n_fill_width;
            r_fill_height <= n_fill_height;
            r_color       <= n_color;
            r_res         <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_step      <= '0;
            r_row       <= '0;
            r_pix       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_active <= n_active;
                r_step   <= n_step;
                r_row    <= n_row;
                r_pix    <= n_pix;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/lcd_rectangle_fill_bus_sequencer.sv
// Rectangle fill sequencer for an 8080-style parallel panel bus. Each request word is
// either a start (captures x, y, width, height and an RGB565 color) or a bus tick; every
// request word yields exactly one result word. While a fill runs, each tick gives one bus
// byte: per row a memory-write command, column-set with start and end columns, row-set with
// the row twice, another memory-write, then width pixels as color high byte then low byte.
// A start during a fill is reported as ignored; a zero width or height ends at once.
// Throughput is one word per clock cycle sustained while the result side is ready. A request
// lands in a two-entry queue; the back sequencer pops it, updating its state and registering
// its result word in the output register at the same edge, and the result word is presented
// from that register. The queue and output register let the request and result sides stall
// independently.
module lcd_rectangle_fill_bus_sequencer import lrf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lrf_req_if.sink   i_req,
    lrf_res_if.source o_res
);

    logic      front_valid;
    logic      front_ready;
    t_cmd      front_cmd;
    logic      back_valid;
    logic      back_ready;
    t_cmd      back_cmd;
    t_q_status q_status;

    lrf_front u_front (
        .i_req       (i_req),
        .i_cmd_ready (front_ready),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd)
    );

    lrf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_cmd   (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop_cmd    (back_cmd),
        .i_pop_ready  (back_ready),
        .o_status     (q_status)
    );

    lrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .i_cmd       (back_cmd),
        .o_cmd_ready (back_ready),
        .o_res       (o_res)
    );

    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= Q_LVL_W'(Q_DEPTH))
        else $error("queue level above depth");

    a_last_ends_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.last |-> o_res.data.write_valid && !o_res.data.busy_res)
        else $error("last word while fill still busy");

    a_ignored_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.start_ignored
        |-> !o_res.data.write_valid && o_res.data.busy_res)
        else $error("ignored start with bus write or idle");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.data.write_valid
        |-> !o_res.data.is_data && o_res.data.bus_byte == '0 && !o_res.data.last)
        else $error("bus fields set without a write");

    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_status.empty && back_ready |=> q_status.level != Q_LVL_W'(Q_DEPTH)
        || $past(front_valid && front_ready))
        else $error("queue did not drain");

endmodule
